[sv/ith_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ith_pkg
// Shared types and constants for the image trailer hash extractor.
// ----------------------------------------------------------------------------
package ith_pkg;

  localparam int IMAGE_BYTES = 65536;

  localparam logic [7:0] MAGIC_LO   = 8'h07;
  localparam logic [7:0] MAGIC_HI   = 8'h69;
  localparam logic [7:0] TAG_SHA256 = 8'h10;
  localparam int         HASH_LEN   = 32;
  localparam int         HDR_LEN    = 4;
  localparam int         HIDX_W     = $clog2(HASH_LEN);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } request_t;

  typedef struct packed {
    logic [7:0] hash_byte;
    logic       hash_valid;
    logic       run_last;
  } result_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SEARCH,
    ST_WALK_TEST,
    ST_WALK_READ,
    ST_WALK_EVAL,
    ST_EMIT,
    ST_FAIL
  } state_t;

endpackage
`default_nettype wire

[sv/image_trailer_hash_extractor.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// image_trailer_hash_extractor
// Stores an image, finds its trailer and returns the SHA-256 hash bytes.
// ----------------------------------------------------------------------------
// Loading: one request per cycle; busy stays low until the final byte is taken.
// Search: bytes are scanned backward from the image end.
// Walk: each trailer entry is end-tested, its type and length are read, then it is evaluated.
// Results: 32 strobes on consecutive cycles after the end test, each through the
// registered read and result, or one not-found strobe via the fail state; no stall.
// Synchronous reset clears control state; the image store is not cleared.
module image_trailer_hash_extractor #(
  parameter int IMAGE_BYTES = ith_pkg::IMAGE_BYTES
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire ith_pkg::request_t request,
  output logic                   done,
  output ith_pkg::result_t       result
);

  localparam int AW = $clog2(IMAGE_BYTES);

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;

  ith_ctrl #(
    .IMAGE_BYTES(IMAGE_BYTES)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .request   (request),
    .done      (done),
    .result    (result),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  ith_mem #(
    .IMAGE_BYTES(IMAGE_BYTES)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule
`default_nettype wire

[sv/ith_mem.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ith_mem
// Image byte store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ith_mem #(
  parameter int IMAGE_BYTES = ith_pkg::IMAGE_BYTES,
  localparam int AW = $clog2(IMAGE_BYTES)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [7:0]    wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [7:0]    rdata
);

  logic [7:0] mem [IMAGE_BYTES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[sv/ith_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ith_ctrl
// Load sequencer, backward trailer search, entry walk and hash readout.
// ----------------------------------------------------------------------------
module ith_ctrl #(
  parameter int IMAGE_BYTES = ith_pkg::IMAGE_BYTES,
  localparam int AW = $clog2(IMAGE_BYTES),
  localparam int CW = AW + 1,
  localparam int SW = ((CW > 17) ? CW : 17) + 1
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire ith_pkg::request_t request,
  output logic                   done,
  output ith_pkg::result_t       result,
  output logic                   mem_we,
  output logic [AW-1:0]          mem_waddr,
  output logic [7:0]             mem_wdata,
  output logic [AW-1:0]          mem_raddr,
  input  wire logic [7:0]        mem_rdata
);

  localparam int HW = ith_pkg::HIDX_W;

  ith_pkg::state_t state, state_next;
  logic [CW-1:0]   count, count_next;
  logic            ovf, ovf_next;
  logic [CW-1:0]   len, len_next;
  logic [AW-1:0]   scan_addr, scan_addr_next;
  logic            scan_issue, scan_issue_next;
  logic            rd_pend, rd_pend_next;
  logic [AW-1:0]   rd_tag, rd_tag_next;
  logic [7:0]      win0, win0_next, win1, win1_next, win2, win2_next;
  logic [SW-1:0]   p, p_next;
  logic [1:0]      step, step_next;
  logic [7:0]      ty, ty_next;
  logic [15:0]     ln, ln_next;
  logic [AW-1:0]   hpos, hpos_next;
  logic            hseen, hseen_next;
  logic [HW:0]     emit_idx, emit_idx_next;
  logic [HW-1:0]   out_idx, out_idx_next;
  logic            done_next;
  ith_pkg::result_t result_next;

  logic            full;
  logic [CW-1:0]   cnt_inc;
  logic            ovf_n;
  logic [SW-1:0]   len_s;
  logic [1:0]      rd_off;

  always_comb begin
    full    = (count == CW'(IMAGE_BYTES));
    cnt_inc = full ? count : count + CW'(1);
    ovf_n   = ovf | full;
    len_s   = SW'(len);
    case (step)
      2'd0:    rd_off = 2'd0;
      2'd1:    rd_off = 2'd2;
      default: rd_off = 2'd3;
    endcase
  end

  always_comb begin
    state_next      = state;
    count_next      = count;
    ovf_next        = ovf;
    len_next        = len;
    scan_addr_next  = scan_addr;
    scan_issue_next = scan_issue;
    rd_pend_next    = 1'b0;
    rd_tag_next     = rd_tag;
    win0_next       = win0;
    win1_next       = win1;
    win2_next       = win2;
    p_next          = p;
    step_next       = step;
    ty_next         = ty;
    ln_next         = ln;
    hpos_next       = hpos;
    hseen_next      = hseen;
    emit_idx_next   = emit_idx;
    out_idx_next    = out_idx;
    done_next       = 1'b0;
    result_next     = result;
    mem_we          = 1'b0;
    mem_waddr       = count[AW-1:0];
    mem_wdata       = request.data_byte;
    mem_raddr       = '0;
    busy            = (state != ith_pkg::ST_LOAD);

    case (state)
      ith_pkg::ST_LOAD: begin
        if (start) begin
          mem_we = !full;
          if (!request.final_byte) begin
            count_next = cnt_inc;
            ovf_next   = ovf_n;
          end else begin
            count_next      = '0;
            ovf_next        = 1'b0;
            len_next        = cnt_inc;
            hseen_next      = 1'b0;
            scan_addr_next  = AW'(cnt_inc - CW'(1));
            scan_issue_next = 1'b1;
            if (ovf_n || (cnt_inc < CW'(ith_pkg::HDR_LEN))) begin
              state_next = ith_pkg::ST_FAIL;
            end else begin
              state_next = ith_pkg::ST_SEARCH;
            end
          end
        end
      end

      ith_pkg::ST_SEARCH: begin
        mem_raddr = scan_addr;
        if (scan_issue) begin
          rd_pend_next = 1'b1;
          rd_tag_next  = scan_addr;
          if (scan_addr == '0) begin
            scan_issue_next = 1'b0;
          end else begin
            scan_addr_next = scan_addr - AW'(1);
          end
        end
        if (rd_pend) begin
          win0_next = mem_rdata;
          win1_next = win0;
          win2_next = win1;
          if ((SW'(rd_tag) + SW'(ith_pkg::HDR_LEN) <= len_s) &&
              (mem_rdata == ith_pkg::MAGIC_LO) && (win0 == ith_pkg::MAGIC_HI) &&
              (SW'(rd_tag) + SW'({win2, win1}) == len_s)) begin
            p_next          = SW'(rd_tag) + SW'(ith_pkg::HDR_LEN);
            scan_issue_next = 1'b0;
            state_next      = ith_pkg::ST_WALK_TEST;
          end else if (rd_tag == '0) begin
            scan_issue_next = 1'b0;
            state_next      = ith_pkg::ST_FAIL;
          end
        end
      end

      ith_pkg::ST_WALK_TEST: begin
        step_next = '0;
        if (p + SW'(ith_pkg::HDR_LEN) > len_s) begin
          emit_idx_next = '0;
          state_next    = hseen ? ith_pkg::ST_EMIT : ith_pkg::ST_FAIL;
        end else begin
          state_next = ith_pkg::ST_WALK_READ;
        end
      end

      ith_pkg::ST_WALK_READ: begin
        mem_raddr    = AW'(p + SW'(rd_off));
        rd_pend_next = (step != 2'd3);
        step_next    = step + 2'd1;
        if (rd_pend) begin
          case (step)
            2'd1:    ty_next = mem_rdata;
            2'd2:    ln_next[7:0] = mem_rdata;
            2'd3: begin
              ln_next[15:8] = mem_rdata;
              state_next    = ith_pkg::ST_WALK_EVAL;
            end
            default: ty_next = ty;
          endcase
        end
      end

      ith_pkg::ST_WALK_EVAL: begin
        p_next     = p + SW'(ln) + SW'(ith_pkg::HDR_LEN);
        state_next = ith_pkg::ST_WALK_TEST;
        if (ty == ith_pkg::TAG_SHA256) begin
          if (hseen) begin
            state_next = ith_pkg::ST_FAIL;
          end else if (ln == 16'(ith_pkg::HASH_LEN)) begin
            if (p + SW'(ith_pkg::HDR_LEN + ith_pkg::HASH_LEN) > len_s) begin
              state_next = ith_pkg::ST_FAIL;
            end else begin
              hpos_next  = AW'(p + SW'(ith_pkg::HDR_LEN));
              hseen_next = 1'b1;
            end
          end
        end
      end

      ith_pkg::ST_EMIT: begin
        mem_raddr = hpos + AW'(emit_idx);
        if (!emit_idx[HW]) begin
          rd_pend_next  = 1'b1;
          out_idx_next  = emit_idx[HW-1:0];
          emit_idx_next = emit_idx + (HW+1)'(1);
        end
        if (rd_pend) begin
          done_next   = 1'b1;
          result_next = '{hash_byte:  mem_rdata,
                          hash_valid: 1'b1,
                          run_last:   (out_idx == HW'(ith_pkg::HASH_LEN - 1))};
          if (out_idx == HW'(ith_pkg::HASH_LEN - 1)) begin
            state_next = ith_pkg::ST_LOAD;
          end
        end
      end

      ith_pkg::ST_FAIL: begin
        done_next   = 1'b1;
        result_next = '{hash_byte: 8'd0, hash_valid: 1'b0, run_last: 1'b1};
        state_next  = ith_pkg::ST_LOAD;
      end

      default: begin
        state_next = ith_pkg::ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ith_pkg::ST_LOAD;
      count      <= '0;
      ovf        <= 1'b0;
      scan_issue <= 1'b0;
      rd_pend    <= 1'b0;
      hseen      <= 1'b0;
      done       <= 1'b0;
    end else begin
      state      <= state_next;
      count      <= count_next;
      ovf        <= ovf_next;
      scan_issue <= scan_issue_next;
      rd_pend    <= rd_pend_next;
      hseen      <= hseen_next;
      done       <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    len       <= len_next;
    scan_addr <= scan_addr_next;
    rd_tag    <= rd_tag_next;
    win0      <= win0_next;
    win1      <= win1_next;
    win2      <= win2_next;
    p         <= p_next;
    step      <= step_next;
    ty        <= ty_next;
    ln        <= ln_next;
    hpos      <= hpos_next;
    emit_idx  <= emit_idx_next;
    out_idx   <= out_idx_next;
    result    <= result_next;
  end

endmodule
`default_nettype wire

[tb/image_trailer_hash_extractor_test.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// image_trailer_hash_extractor_test
// Sends whole firmware images one byte per request, directed trailer layouts
// first, then random ones. Results are taken from the case row or predicted
// from a local image copy; every result is checked field by field, in order.
// ----------------------------------------------------------------------------
module image_trailer_hash_extractor_test;

  typedef enum logic [3:0] {
    IMG_TINY,
    IMG_NO_MAGIC,
    IMG_HEADER_ONLY,
    IMG_HASH,
    IMG_DECOY,
    IMG_WRONG_LEN_TAG,
    IMG_TWO_HASH,
    IMG_LATE_TAG,
    IMG_HASH_CUT,
    IMG_TAIL,
    IMG_LONG_SKIP,
    IMG_SKIP_HASH,
    IMG_FULL,
    IMG_OVERFLOW,
    IMG_MIXED
  } image_kind_t;

  typedef struct packed {
    image_kind_t      kind;
    logic [7:0]       size;
    logic [8:0]       fill;
    logic             typed;
    ith_pkg::result_t want;
  } image_case_t;

  localparam int               MEM_BYTES   = 128;
  localparam logic [8:0]       RND         = 9'h100;
  localparam ith_pkg::result_t NOT_FOUND   = '{hash_byte: 8'h00, hash_valid: 1'b0,
                                               run_last: 1'b1};
  localparam ith_pkg::result_t PREDICTED   = '0;
  localparam int               FULL_BODY   = 20;
  localparam int               FULL_FILL   = MEM_BYTES - FULL_BODY -
                                             3 * ith_pkg::HDR_LEN - ith_pkg::HASH_LEN;
  localparam int               QUIET_LIMIT = 300000;

  logic              clk;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  ith_pkg::request_t request = '0;
  logic              done;
  ith_pkg::result_t  result;

  logic [7:0]       image_q[$];
  int               build_trailer_at;
  bit               steady = 1'b0;
  int               requests_sent = 0;
  logic             typed_on = 1'b0;
  ith_pkg::result_t typed_res = '0;

  logic [7:0]       image_mem [MEM_BYTES];
  int               load_count = 0;
  bit               load_overflow = 1'b0;
  ith_pkg::result_t hash_results_due[$];
  int               errors = 0;

  image_case_t directed_cases [16] = '{
    '{IMG_TINY,          8'd1,  RND,    1'b1, NOT_FOUND},
    '{IMG_TINY,          8'd3,  9'h0FF, 1'b1, NOT_FOUND},
    '{IMG_HEADER_ONLY,   8'd0,  RND,    1'b1, NOT_FOUND},
    '{IMG_NO_MAGIC,      8'd30, RND,    1'b1, NOT_FOUND},
    '{IMG_HASH,          8'd0,  9'h000, 1'b0, PREDICTED},
    '{IMG_HASH,          8'd5,  9'h0FF, 1'b0, PREDICTED},
    '{IMG_DECOY,         8'd7,  RND,    1'b0, PREDICTED},
    '{IMG_WRONG_LEN_TAG, 8'd3,  RND,    1'b0, PREDICTED},
    '{IMG_TWO_HASH,      8'd2,  RND,    1'b1, NOT_FOUND},
    '{IMG_LATE_TAG,      8'd0,  RND,    1'b1, NOT_FOUND},
    '{IMG_HASH_CUT,      8'd20, RND,    1'b1, NOT_FOUND},
    '{IMG_TAIL,          8'd3,  RND,    1'b0, PREDICTED},
    '{IMG_LONG_SKIP,     8'd4,  RND,    1'b0, PREDICTED},
    '{IMG_SKIP_HASH,     8'd0,  RND,    1'b1, NOT_FOUND},
    '{IMG_FULL,          8'd0,  RND,    1'b0, PREDICTED},
    '{IMG_OVERFLOW,      8'd1,  RND,    1'b1, NOT_FOUND}
  };

  image_trailer_hash_extractor #(
    .IMAGE_BYTES(MEM_BYTES)
  ) uut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit sha_lookup(input int len, output int at);
    int pos;
    int p;
    int ln;
    bit hit;
    bit seen;
    bit bad;
    at = 0;
    if (load_overflow || len < ith_pkg::HDR_LEN) return 1'b0;
    pos = len - ith_pkg::HDR_LEN;
    hit = 1'b0;
    while (pos >= 0 && !hit) begin
      if (image_mem[pos] == ith_pkg::MAGIC_LO && image_mem[pos + 1] == ith_pkg::MAGIC_HI &&
          pos + int'({image_mem[pos + 3], image_mem[pos + 2]}) == len) begin
        hit = 1'b1;
      end else begin
        pos--;
      end
    end
    if (!hit) return 1'b0;
    seen = 1'b0;
    bad = 1'b0;
    p = pos + ith_pkg::HDR_LEN;
    while (p < len && len - p >= ith_pkg::HDR_LEN && !bad) begin
      ln = int'({image_mem[p + 3], image_mem[p + 2]});
      if (image_mem[p] == ith_pkg::TAG_SHA256) begin
        if (seen) begin
          bad = 1'b1;
        end else if (ln == ith_pkg::HASH_LEN) begin
          if (len - (p + ith_pkg::HDR_LEN) < ith_pkg::HASH_LEN) begin
            bad = 1'b1;
          end else begin
            at = p + ith_pkg::HDR_LEN;
            seen = 1'b1;
          end
        end
      end
      p += ln + ith_pkg::HDR_LEN;
    end
    return seen && !bad;
  endfunction

  always @(posedge clk) begin : check_proc
    ith_pkg::result_t want;
    int at;
    if (!rst) begin
      if (start && !busy) begin
        if (load_count < MEM_BYTES) begin
          image_mem[load_count] = request.data_byte;
          load_count++;
        end else begin
          load_overflow = 1'b1;
        end
        if (request.final_byte) begin
          if (typed_on) begin
            hash_results_due.push_back(typed_res);
          end else if (sha_lookup(load_count, at)) begin
            for (int i = 0; i < ith_pkg::HASH_LEN; i++)
              hash_results_due.push_back(ith_pkg::result_t'{image_mem[at + i], 1'b1,
                                                             i == ith_pkg::HASH_LEN - 1});
          end else begin
            hash_results_due.push_back(NOT_FOUND);
          end
          load_count = 0;
          load_overflow = 1'b0;
        end
      end
      if (done) begin
        if (hash_results_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %p", $time, result);
          errors++;
        end else begin
          want = hash_results_due.pop_front();
          if (result.hash_byte !== want.hash_byte) begin
            $display("%0t: hash_byte expected %02h got %02h", $time, want.hash_byte,
                     result.hash_byte);
            errors++;
          end
          if (result.hash_valid !== want.hash_valid) begin
            $display("%0t: hash_valid expected %0b got %0b", $time, want.hash_valid,
                     result.hash_valid);
            errors++;
          end
          if (result.run_last !== want.run_last) begin
            $display("%0t: run_last expected %0b got %0b", $time, want.run_last,
                     result.run_last);
            errors++;
          end
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || done) quiet = 0;
      else quiet++;
    end
    $display("%0t: timeout, no request or result for %0d cycles", $time, QUIET_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  task automatic add_bytes(input int n, input logic [8:0] fill);
    repeat (n) image_q.push_back(fill[8] ? 8'($urandom) : fill[7:0]);
  endtask

  task automatic add_magic(input logic [15:0] tl);
    image_q.push_back(ith_pkg::MAGIC_LO);
    image_q.push_back(ith_pkg::MAGIC_HI);
    image_q.push_back(tl[7:0]);
    image_q.push_back(tl[15:8]);
  endtask

  task automatic add_entry(input logic [7:0] tag, input int ln, input int n,
                           input logic [8:0] fill);
    image_q.push_back(tag);
    image_q.push_back(8'($urandom));
    image_q.push_back(ln[7:0]);
    image_q.push_back(ln[15:8]);
    add_bytes(n, fill);
  endtask

  task automatic open_trailer();
    build_trailer_at = image_q.size();
    add_magic(16'h0000);
  endtask

  task automatic close_trailer();
    int tl;
    tl = image_q.size() - build_trailer_at;
    image_q[build_trailer_at + 2] = tl[7:0];
    image_q[build_trailer_at + 3] = tl[15:8];
  endtask

  function automatic logic [7:0] other_tag();
    logic [7:0] t;
    t = 8'($urandom);
    if (t == ith_pkg::TAG_SHA256) t = 8'h11;
    return t;
  endfunction

  task automatic build_image(input image_kind_t kind, input int size, input logic [8:0] fill);
    int roll;
    int ln;
    image_q.delete();
    build_trailer_at = -1;
    case (kind)
      IMG_TINY: add_bytes(size, fill);
      IMG_NO_MAGIC: begin
        add_bytes(size, fill);
        foreach (image_q[i]) if (image_q[i] == ith_pkg::MAGIC_LO) image_q[i] = 8'h08;
      end
      IMG_HEADER_ONLY: begin
        add_bytes(size, RND);
        open_trailer();
      end
      IMG_HASH: begin
        add_bytes(size, RND);
        open_trailer();
        add_entry(ith_pkg::TAG_SHA256, ith_pkg::HASH_LEN, ith_pkg::HASH_LEN, fill);
      end
      IMG_DECOY: begin
        add_bytes(size, RND);
        add_magic(16'h0003);
        open_trailer();
        add_entry(8'h22, 4, 0, RND);
        add_magic(16'h00FF);
        add_entry(ith_pkg::TAG_SHA256, ith_pkg::HASH_LEN, ith_pkg::HASH_LEN, RND);
      end
      IMG_WRONG_LEN_TAG: begin
        add_bytes(size, RND);
        open_trailer();
        add_entry(ith_pkg::TAG_SHA256, 0, 0, RND);
        add_entry(ith_pkg::TAG_SHA256, ith_pkg::HASH_LEN - 1, ith_pkg::HASH_LEN - 1, RND);
        add_entry(ith_pkg::TAG_SHA256, ith_pkg::HASH_LEN, ith_pkg::HASH_LEN, RND);
      end
      IMG_TWO_HASH: begin
        add_bytes(size, RND);
        open_trailer();
        add_entry(ith_pkg::TAG_SHA256, ith_pkg::HASH_LEN, ith_pkg::HASH_LEN, RND);
        add_entry(ith_pkg::TAG_SHA256, ith_pkg::HASH_LEN, ith_pkg::HASH_LEN, RND);
      end
      IMG_LATE_TAG: begin
        add_bytes(size, RND);
        open_trailer();
        add_entry(ith_pkg::TAG_SHA256, ith_pkg::HASH_LEN, ith_pkg::HASH_LEN, RND);
        add_entry(ith_pkg::TAG_SHA256, 5, 5, RND);
      end
      IMG_HASH_CUT: begin
        open_trailer();
        add_entry(ith_pkg::TAG_SHA256, ith_pkg::HASH_LEN, size, RND);
      end
      IMG_TAIL: begin
        open_trailer();
        add_entry(ith_pkg::TAG_SHA256, ith_pkg::HASH_LEN, ith_pkg::HASH_LEN, RND);
        add_bytes(size, RND);
      end
      IMG_LONG_SKIP: begin
        open_trailer();
        add_entry(ith_pkg::TAG_SHA256, ith_pkg::HASH_LEN, ith_pkg::HASH_LEN, RND);
        add_entry(other_tag(), 16'hFFFF, size, RND);
      end
      IMG_SKIP_HASH: begin
        open_trailer();
        add_entry(other_tag(), 100, 0, RND);
        add_entry(ith_pkg::TAG_SHA256, ith_pkg::HASH_LEN, ith_pkg::HASH_LEN, RND);
      end
      IMG_FULL, IMG_OVERFLOW: begin
        add_bytes(FULL_BODY, RND);
        open_trailer();
        add_entry(8'h20, FULL_FILL, FULL_FILL, RND);
        add_entry(ith_pkg::TAG_SHA256, ith_pkg::HASH_LEN, ith_pkg::HASH_LEN, RND);
        close_trailer();
        build_trailer_at = -1;
        if (kind == IMG_OVERFLOW) add_bytes(size, RND);
      end
      IMG_MIXED: begin
        roll = $urandom_range(99);
        if (roll < 10) begin
          add_bytes($urandom_range(1, 48), RND);
        end else begin
          add_bytes($urandom_range(0, 20), RND);
          open_trailer();
          repeat ($urandom_range(0, 2)) begin
            ln = $urandom_range(0, 6);
            add_entry(other_tag(), ln, ln, RND);
          end
          if (roll < 16) begin
            ln = $urandom_range(0, 40);
            if (ln == ith_pkg::HASH_LEN) ln++;
            add_entry(ith_pkg::TAG_SHA256, ln, ln, RND);
          end
          if (roll >= 20)
            add_entry(ith_pkg::TAG_SHA256, ith_pkg::HASH_LEN, ith_pkg::HASH_LEN, RND);
          repeat ($urandom_range(0, 2)) begin
            ln = $urandom_range(0, 6);
            add_entry(other_tag(), ln, ln, RND);
          end
          if (roll >= 84 && roll < 88) begin
            ln = $urandom_range(0, 40);
            add_entry(ith_pkg::TAG_SHA256, ln, ln, RND);
          end
          if (roll >= 88 && roll < 94) add_bytes($urandom_range(1, 3), RND);
          close_trailer();
          if (roll >= 94)
            image_q[build_trailer_at + 2] = image_q[build_trailer_at + 2] ^
                                            (8'h01 << $urandom_range(7));
          build_trailer_at = -1;
        end
      end
      default: add_bytes(1, RND);
    endcase
    if (build_trailer_at >= 0) close_trailer();
  endtask

  task automatic send_byte(input logic [7:0] b, input logic fin);
    while (!steady && $urandom_range(99) < 15) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    request <= '{data_byte: b, final_byte: fin};
    @(posedge clk);
    while (busy) @(posedge clk);
    requests_sent++;
  endtask

  task automatic send_image(input logic typed, input ith_pkg::result_t want);
    typed_on <= typed;
    typed_res <= want;
    foreach (image_q[i]) send_byte(image_q[i], i == image_q.size() - 1);
  endtask

  initial begin : stimulus
    image_case_t row;
    int images;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    foreach (directed_cases[k]) begin
      row = directed_cases[k];
      build_image(row.kind, row.size, row.fill);
      send_image(row.typed, row.want);
    end
    // hold off until every hash result is back
    start <= 1'b0;
    @(posedge clk);
    while (hash_results_due.size() != 0) @(posedge clk);
    requests_sent = 0;
    images = 0;
    while (requests_sent < 320 || images < 6) begin
      steady = (images >= 1 && images < 4);
      build_image(IMG_MIXED, 0, RND);
      send_image(1'b0, PREDICTED);
      images++;
    end
    start <= 1'b0;
    @(posedge clk);
    while (hash_results_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
